FILE: hw/rtl/atilt_pkg.sv
// atilt_pkg: shared widths, constants, types and the arctangent table
// for the accelerometer tilt to servo pulse block
// no dependencies
package atilt_pkg;

  // sample and datapath widths
  localparam int SAMPLE_WIDTH  = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int QW  = SAMPLE_WIDTH + 8;        // sample in q8
  localparam int NW  = 2 * SAMPLE_WIDTH + 16;   // sum of squares in q16
  localparam int RW  = NW / 2;                  // magnitude in q8
  localparam int CW  = QW + 4;                  // cordic x/y with gain headroom
  localparam int AW  = 18;                      // angle in q8 degrees
  localparam int OFF_W = 10;                    // offset register width
  localparam int VW  = AW + 2;                  // offset plus angle
  localparam int DW  = 8;                       // whole degrees 0..180
  localparam int PW  = 12;                      // pulse width field
  localparam int MW  = 28;                      // reciprocal product

  // stream payload widths
  localparam int IN_W  = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_W = ((2 * PW + 7) / 8) * 8;

  // angle constants in q8 degrees
  localparam logic signed [AW-1:0] DEG90_Q8      = AW'(90 * 256);
  localparam logic signed [AW-1:0] DEG180_NEG_Q8 = AW'(-180 * 256);

  // pulse mapping: 500 + d*2000/180, divide done by reciprocal
  localparam int ANGLE_MAX    = 180;
  localparam int PULSE_BASE   = 500;
  localparam int PULSE_MAX    = 2500;
  localparam int PULSE_RECIP  = 728178;       // 2000/180 * 2^16, rounded up
  localparam int RECIP_SHIFT  = 16;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // configuration registers
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_ROLL  = 1'b0;
  localparam logic REG_PITCH = 1'b1;
  localparam logic signed [OFF_W-1:0] ROLL_OFF_RST  = OFF_W'(90);
  localparam logic signed [OFF_W-1:0] PITCH_OFF_RST = OFF_W'(150);

  typedef struct packed {
    logic signed [AW-1:0] roll;
    logic signed [AW-1:0] pitch;
  } atilt_angles_t;

  typedef struct packed {
    logic full;
    logic empty;
  } atilt_fifo_st_t;

  // arctangent of 2^-i in q8 degrees
  function automatic logic signed [AW-1:0] atan_q8(input int i);
    logic signed [AW-1:0] r;
    case (i)
      0:  r = AW'(11520);
      1:  r = AW'(6801);
      2:  r = AW'(3593);
      3:  r = AW'(1824);
      4:  r = AW'(916);
      5:  r = AW'(458);
      6:  r = AW'(229);
      7:  r = AW'(115);
      8:  r = AW'(57);
      9:  r = AW'(29);
      10: r = AW'(14);
      11: r = AW'(7);
      12: r = AW'(4);
      13: r = AW'(2);
      14: r = AW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/atilt_cordic.sv
// atilt_cordic: pipelined vectoring cordic, atan2(y, x) in q8 degrees
// one pre-rotation stage plus CORDIC_STAGES stages; depends on atilt_pkg
module atilt_cordic (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [atilt_pkg::CW-1:0] x_in,
  input  logic signed [atilt_pkg::CW-1:0] y_in,
  output logic signed [atilt_pkg::AW-1:0] z_out
);
  import atilt_pkg::*;

  localparam int N = CORDIC_STAGES;

  logic signed [CW-1:0] x [0:N];
  logic signed [CW-1:0] y [0:N];
  logic signed [AW-1:0] z [0:N];
  logic                 zf [0:N];

  // pre-rotation into the right half plane, zero vector flagged
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x[0] <= y_in;
          y[0] <= -x_in;
          z[0] <= DEG90_Q8;
        end else begin
          x[0] <= -y_in;
          y[0] <= x_in;
          z[0] <= -DEG90_Q8;
        end
      end else begin
        x[0] <= x_in;
        y[0] <= y_in;
        z[0] <= '0;
      end
    end
  end

  // micro-rotations, zero residual steers as negative
  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN_I = atan_q8(i);
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (y[i] > 0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATAN_I;
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATAN_I;
        end
      end
    end
  end

  assign z_out = zf[N] ? '0 : z[N];

endmodule

FILE: hw/rtl/atilt_front.sv
// atilt_front: accepts samples and computes roll and pitch in q8 degrees
// squares, pipelined integer square root, two cordic pipelines
// depends on atilt_pkg and atilt_cordic
module atilt_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [atilt_pkg::IN_W-1:0]     s_tdata,   // accel_x, accel_y, accel_z
  input  atilt_pkg::atilt_fifo_st_t      fifo_st,
  output logic                           push,
  output atilt_pkg::atilt_angles_t       push_data
);
  import atilt_pkg::*;

  localparam int W  = SAMPLE_WIDTH;
  localparam int CL = CORDIC_STAGES + 1;

  logic en;

  // whole pipeline advances while the queue has room
  assign en       = !fifo_st.full;
  assign s_tready = en;

  // input register
  logic                v0;
  logic signed [W-1:0] ax0, ay0, az0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax0 <= s_tdata[W-1:0];
      ay0 <= s_tdata[2*W-1:W];
      az0 <= s_tdata[3*W-1:2*W];
    end
  end

  // squares
  logic                  v1;
  logic signed [2*W-1:0] sqx1, sqz1;
  logic signed [W-1:0]   ax1, ay1, az1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx1 <= ax0 * ax0;
      sqz1 <= az0 * az0;
      ax1  <= ax0;
      ay1  <= ay0;
      az1  <= az0;
    end
  end

  // square root, one result bit per stage
  logic                sv  [0:RW];
  logic [NW-1:0]       rem [0:RW];
  logic [RW-1:0]       root [0:RW];
  logic signed [W-1:0] axs [0:RW];
  logic signed [W-1:0] ays [0:RW];
  logic signed [W-1:0] azs [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= v1;
    end
  end

  // sum of squares in q16
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= {$unsigned(sqx1) + $unsigned(sqz1), 16'b0};
      root[0] <= '0;
      axs[0]  <= ax1;
      ays[0]  <= ay1;
      azs[0]  <= az1;
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int K = RW - 1 - j;
    logic [NW-1:0] trial;
    logic          take;

    assign trial = ({{(NW-RW){1'b0}}, root[j]} << (K + 1))
                 | ({{(NW-1){1'b0}}, 1'b1} << (2 * K));
    assign take  = rem[j] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else if (en) begin
        sv[j+1] <= sv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= take ? rem[j] - trial : rem[j];
        root[j+1] <= take ? (root[j] | ({{(RW-1){1'b0}}, 1'b1} << K)) : root[j];
        axs[j+1]  <= axs[j];
        ays[j+1]  <= ays[j];
        azs[j+1]  <= azs[j];
      end
    end
  end

  // cordic operands
  logic signed [CW-1:0] axw, ayw, azw;
  logic signed [CW-1:0] roll_x, roll_y, pitch_x, pitch_y;
  logic                 pitch_flip;

  assign axw        = CW'(axs[RW]);
  assign ayw        = CW'(ays[RW]);
  assign azw        = CW'(azs[RW]);
  assign roll_x     = {{(CW-RW){1'b0}}, root[RW]};
  assign roll_y     = ayw <<< 8;
  assign pitch_x    = azw <<< 8;
  assign pitch_y    = -(axw <<< 8);
  // zero x with negative z: negated zero makes pitch exactly -180
  assign pitch_flip = (axs[RW] == '0) && (azs[RW] < 0);

  logic signed [AW-1:0] z_roll, z_pitch;

  atilt_cordic u_roll (
    .clk   (clk),
    .en    (en),
    .x_in  (roll_x),
    .y_in  (roll_y),
    .z_out (z_roll)
  );

  atilt_cordic u_pitch (
    .clk   (clk),
    .en    (en),
    .x_in  (pitch_x),
    .y_in  (pitch_y),
    .z_out (z_pitch)
  );

  // valid and special flag alongside the cordic stages
  logic cv [0:CL-1];
  logic cs [0:CL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= sv[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs[0] <= pitch_flip;
    end
  end

  for (genvar c = 1; c < CL; c++) begin : g_cdly
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[c] <= 1'b0;
      end else if (en) begin
        cv[c] <= cv[c-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cs[c] <= cs[c-1];
      end
    end
  end

  // request into the queue
  assign push            = en && cv[CL-1];
  assign push_data.roll  = z_roll;
  assign push_data.pitch = cs[CL-1] ? DEG180_NEG_Q8 : z_pitch;

endmodule

FILE: hw/rtl/atilt_fifo.sv
// atilt_fifo: short queue of angle pairs between front and back
// depends on atilt_pkg
module atilt_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  atilt_pkg::atilt_angles_t  push_data,
  input  logic                      pop,
  output atilt_pkg::atilt_angles_t  pop_data,
  output atilt_pkg::atilt_fifo_st_t st
);
  import atilt_pkg::*;

  atilt_angles_t      mem [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_CW-1:0] count;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_data = mem[rptr];
  assign st.full  = (count == FIFO_CW'(FIFO_DEPTH));
  assign st.empty = (count == '0);

endmodule

FILE: hw/rtl/atilt_back.sv
// atilt_back: applies offsets, clamps to 0..180 and maps to pulse widths
// two stages with output register; depends on atilt_pkg
module atilt_back (
  input  logic                            clk,
  input  logic                            rst,
  input  atilt_pkg::atilt_fifo_st_t       fifo_st,
  input  atilt_pkg::atilt_angles_t        pop_data,
  output logic                            pop,
  input  logic signed [atilt_pkg::OFF_W-1:0] roll_off,
  input  logic signed [atilt_pkg::OFF_W-1:0] pitch_off,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [atilt_pkg::OUT_W-1:0]     m_tdata    // roll_pulse_us, pitch_pulse_us
);
  import atilt_pkg::*;

  // offset, truncate toward zero, clamp to whole degrees 0..180
  function automatic logic [DW-1:0] to_deg(input logic signed [AW-1:0] ang,
                                           input logic signed [OFF_W-1:0] off);
    logic signed [VW-1:0] v;
    logic [VW-9:0]        q;
    logic [DW-1:0]        d;
    v = {{(VW-OFF_W-8){off[OFF_W-1]}}, off, 8'b0} + VW'(ang);
    q = v[VW-1:8];
    if (v < 0) begin
      d = '0;
    end else if (q > (VW-8)'(ANGLE_MAX)) begin
      d = DW'(ANGLE_MAX);
    end else begin
      d = q[DW-1:0];
    end
    return d;
  endfunction

  // 500 + d*2000/180 by reciprocal multiply
  function automatic logic [PW-1:0] to_pulse(input logic [DW-1:0] d);
    logic [MW-1:0] prod;
    prod = MW'(d) * MW'(PULSE_RECIP);
    return PW'(PULSE_BASE) + PW'(prod >> RECIP_SHIFT);
  endfunction

  logic          out_en, a_ready;
  logic          a_v;
  logic [DW-1:0] d_roll, d_pitch;
  logic [PW-1:0] roll_pulse, pitch_pulse;

  assign out_en  = !m_tvalid || m_tready;
  assign a_ready = !a_v || out_en;
  assign pop     = !fifo_st.empty && a_ready;

  // degree stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_ready) begin
      a_v <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      d_roll  <= to_deg(pop_data.roll, roll_off);
      d_pitch <= to_deg(pop_data.pitch, pitch_off);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_en) begin
      m_tvalid <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      roll_pulse  <= to_pulse(d_roll);
      pitch_pulse <= to_pulse(d_pitch);
    end
  end

  assign m_tdata = OUT_W'({pitch_pulse, roll_pulse});

endmodule

FILE: hw/rtl/accel_tilt_to_servo_pulse.sv
// accel_tilt_to_servo_pulse: top level, configuration registers and assertions
// depends on atilt_pkg, atilt_front, atilt_fifo, atilt_back
//
// Usage:
//   s_* stream: one request per accelerometer sample, tdata holds accel_x,
//   accel_y, accel_z (16-bit two's complement, x lowest).
//   m_* stream: one request per sample, tdata holds roll_pulse_us and
//   pitch_pulse_us (12 bits each, roll lowest), values 500..2500.
//   APB port: register 0 (address 0) roll offset, register 1 (address 4)
//   pitch offset, 10-bit signed degrees; write only while the block is idle.
// Pipeline: with 16-bit samples and 16 cordic stages, an accepted sample passes
//   input, squares, sum, 24 square root stages, 17 cordic stages, queue,
//   degree stage and output register on its way to m_tvalid.
// Throughput: one sample per cycle while s_tready is high; every square root
//   and cordic stage is its own register, so samples follow back to back.
// Reset: synchronous, clears all valid flags and the queue; offsets return
//   to 90 (roll) and 150 (pitch).
// Stall: when m_tready is low the back end holds, the four-entry queue fills
//   and then the whole front pipeline freezes with s_tready low.
module accel_tilt_to_servo_pulse (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [atilt_pkg::IN_W-1:0]          s_tdata,   // accel_x, accel_y, accel_z
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [atilt_pkg::OUT_W-1:0]         m_tdata,   // roll_pulse_us, pitch_pulse_us
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [atilt_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import atilt_pkg::*;

  logic signed [OFF_W-1:0] roll_off, pitch_off;
  logic                    cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_off  <= ROLL_OFF_RST;
      pitch_off <= PITCH_OFF_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ROLL) begin
        roll_off <= pwdata[OFF_W-1:0];
      end else begin
        pitch_off <= pwdata[OFF_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_PITCH) ? 32'(pitch_off) : 32'(roll_off);

  // front, queue, back
  logic           push, pop;
  atilt_angles_t  push_data, pop_data;
  atilt_fifo_st_t fst;

  atilt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .fifo_st   (fst),
    .push      (push),
    .push_data (push_data)
  );

  atilt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .st        (fst)
  );

  atilt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .fifo_st   (fst),
    .pop_data  (pop_data),
    .pop       (pop),
    .roll_off  (roll_off),
    .pitch_off (pitch_off),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // no result shows right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // both pulses stay in servo range
  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[PW-1:0] >= PW'(PULSE_BASE)) &&
                 (m_tdata[PW-1:0] <= PW'(PULSE_MAX)) &&
                 (m_tdata[2*PW-1:PW] >= PW'(PULSE_BASE)) &&
                 (m_tdata[2*PW-1:PW] <= PW'(PULSE_MAX)))
    else $error("pulse width out of range");

  // a roll offset write lands in the register
  a_roll_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && (paddr[2] == REG_ROLL)) |=> (roll_off == $past(pwdata[OFF_W-1:0])))
    else $error("roll offset write lost");

  // an empty queue never pops
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    fst.empty |-> !pop)
    else $error("pop from empty queue");

endmodule

FILE: tb/sv/tb.sv
// tb: stream and register testbench for accel_tilt_to_servo_pulse
// depends on atilt_pkg and the accel_tilt_to_servo_pulse rtl
`timescale 1ns / 100ps

module tb;
  import atilt_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_ROLL  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] ADDR_PITCH = CFG_ADDR_W'(4);
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [PW-1:0] pitch_us;
    logic [PW-1:0] roll_us;
  } pulse_pair_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_W-1:0] s_tdata;   // accel_x, accel_y, accel_z
  logic m_tvalid;
  logic m_tready;
  logic [OUT_W-1:0] m_tdata;  // roll_pulse_us, pitch_pulse_us
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  accel_tilt_to_servo_pulse i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of the offsets
  longint roll_off;
  longint pitch_off;

  pulse_pair_t pulse_q[$];
  int n_errors;
  int n_sent;
  int n_checked;
  bit calm;   // no idling on either side

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  // integer square root, floor
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint atan_deg_q8(input int i);
    longint tbl[15] = '{11520, 6801, 3593, 1824, 916, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1};
    return (i < 15) ? tbl[i] : 0;
  endfunction

  // vectoring cordic angle of (x, y) in q8 degrees
  function automatic longint vector_angle(input longint y, input longint x);
    longint z;
    longint t;
    longint nx;
    longint ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // left half plane: pre-rotate by a quarter turn
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 256;
      end else begin
        x = -y; y = t; z = -90 * 256;
      end
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      // zero residual steers as negative
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_deg_q8(i);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_deg_q8(i);
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  function automatic logic [PW-1:0] servo_width_us(input longint ang, input longint off);
    longint v;
    longint d;
    v = off * 256 + ang;
    d = (v >= 0) ? (v >>> 8) : -((-v) >>> 8);
    if (d < 0) d = 0;
    if (d > 180) d = 180;
    return PW'(500 + (d * 2000) / 180);
  endfunction

  function automatic pulse_pair_t predict_pulses(input logic signed [15:0] ax,
                                                 input logic signed [15:0] ay,
                                                 input logic signed [15:0] az);
    longint x;
    longint y;
    longint z;
    longint mag;
    longint roll;
    longint pitch;
    pulse_pair_t p;
    x = ax; y = ay; z = az;
    mag = longint'(int_sqrt(longint'(x * x + z * z) << 16));
    roll = vector_angle(y * 256, mag);
    // negative zero x with negative z lands on -180
    if (x == 0 && z < 0) pitch = -180 * 256;
    else pitch = vector_angle(-x * 256, z * 256);
    p.roll_us = servo_width_us(roll, roll_off);
    p.pitch_us = servo_width_us(pitch, pitch_off);
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // sink: random stall, check every result request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pulse_q.size() == 0) begin
          report_mismatch("unexpected result", int'(m_tdata[PW-1:0]), -1);
        end else begin
          pulse_pair_t want;
          want = pulse_q.pop_front();
          n_checked++;
          if (m_tdata[PW-1:0] !== want.roll_us)
            report_mismatch("roll_pulse_us", int'(m_tdata[PW-1:0]), int'(want.roll_us));
          if (m_tdata[2*PW-1:PW] !== want.pitch_us)
            report_mismatch("pitch_pulse_us", int'(m_tdata[2*PW-1:PW]),
                            int'(want.pitch_us));
        end
      end
      m_tready <= calm || ($urandom_range(99) >= 18);
    end
  end

  task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az);
    while (!calm && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= IN_W'({az, ay, ax});
    s_tvalid <= 1'b1;
    pulse_q.push_back(predict_pulses(ax, ay, az));
    n_sent++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pulse_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr;
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_ROLL) roll_off = longint'(signed'(10'(val)));
    else pitch_off = longint'(signed'(10'(val)));
    @(posedge clk);
  endtask

  task automatic send_random(input int n);
    logic [15:0] ax, ay, az;
    for (int i = 0; i < n; i++) begin
      ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
      // some small tilts and axis-aligned samples
      case ($urandom_range(5))
        0: begin ax = 16'($signed($urandom_range(64)) - 32); az = 16'($urandom_range(64)); end
        1: ax = '0;
        2: ay = '0;
        default: ;
      endcase
      send_sample(ax, ay, az);
    end
  endtask

  task automatic test_directed();
    logic [15:0] ext[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0100, 16'hff00);  // negative z, zero x
    send_sample(16'h0100, 16'h0000, 16'hff00);  // left half plane
    send_sample(16'hff00, 16'h0000, 16'hff00);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff);
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 3; j++)
        send_sample(ext[i], ext[(i + j) % 5], ext[(i + 2 * j) % 5]);
    wait_idle();
  endtask

  task automatic test_offsets();
    int offs[6] = '{-180, 360, 0, -1, 511, -512};
    for (int k = 0; k < 6; k++) begin
      write_reg(ADDR_ROLL, offs[k]);
      write_reg(ADDR_PITCH, offs[5 - k]);
      send_random(40);
      wait_idle();
    end
    write_reg(ADDR_ROLL, 90);
    write_reg(ADDR_PITCH, 150);
  endtask

  task automatic test_random_stream();
    send_random(150);
    calm = 1'b1;
    send_random(100);
    calm = 1'b0;
    send_random(60);
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    roll_off = 90; pitch_off = 150;
    n_errors = 0; n_sent = 0; n_checked = 0; calm = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_stream();
    test_offsets();
    $display("sent %0d samples, checked %0d pulse pairs over 7 offset settings",
             n_sent, n_checked);
    $display("mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
